@@ sv/ptts_pkg.sv @@
// Shared types and constants for the periodic task tick scheduler.
`timescale 1ns / 1ps

package ptts_pkg;

  localparam int NUM_TASKS_DEF = 8;
  localparam int MAX_OUT       = 8;
  localparam int QUEUE_DEPTH   = 2;
  localparam int CNT_W         = $clog2(MAX_OUT + 1);

  localparam int MODE_W  = 3;
  localparam int ID_W    = 3;
  localparam int PER_W   = 16;
  localparam int DELAY_W = 8;
  localparam int CD_W    = 16;

  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CREATE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_KILL    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SUSPEND = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RESUME  = 3'd4;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_CREATE,
    OP_KILL,
    OP_SUSPEND,
    OP_RESUME
  } op_t;

  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_READY     = 2'd1,
    ST_SUSPENDED = 2'd2
  } task_st_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_WALK,
    B_TAIL,
    B_DONE
  } back_state_t;

  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]  id;
    logic [CD_W-1:0]  reload;
    logic [CD_W-1:0]  delay;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ sv/ptts_front.sv @@
// Front end: accepts commands, drops invalid ones, prepares create values.
`timescale 1ns / 1ps

module ptts_front #(
  parameter int NUM_TASKS = ptts_pkg::NUM_TASKS_DEF
) (
  input  logic                           start,
  input  logic [ptts_pkg::MODE_W-1:0]    mode,
  input  logic [ptts_pkg::ID_W-1:0]      task_id,
  input  logic [ptts_pkg::PER_W-1:0]     period,
  input  logic [ptts_pkg::DELAY_W-1:0]   first_delay,
  input  ptts_pkg::q_stat_t              q_stat,
  output logic                           busy,
  output logic                           push,
  output ptts_pkg::cmd_t                 cmd
);

  logic accept;
  logic id_ok;
  logic keep;

  assign busy   = q_stat.full;
  assign accept = start && !q_stat.full;
  assign id_ok  = 32'(task_id) < NUM_TASKS;

  always_comb begin
    keep       = 1'b0;
    cmd.op     = ptts_pkg::OP_TICK;
    cmd.id     = task_id;
    // a zero period saturates to one, so the reload is never below zero
    cmd.reload = (period == '0) ? '0 : period - 16'd1;
    cmd.delay  = {{(ptts_pkg::CD_W - ptts_pkg::DELAY_W){1'b0}}, first_delay};
    case (mode)
      ptts_pkg::MODE_TICK: begin
        keep   = 1'b1;
        cmd.op = ptts_pkg::OP_TICK;
      end
      ptts_pkg::MODE_CREATE: begin
        keep   = id_ok;
        cmd.op = ptts_pkg::OP_CREATE;
      end
      ptts_pkg::MODE_KILL: begin
        keep   = id_ok;
        cmd.op = ptts_pkg::OP_KILL;
      end
      ptts_pkg::MODE_SUSPEND: begin
        keep   = id_ok;
        cmd.op = ptts_pkg::OP_SUSPEND;
      end
      ptts_pkg::MODE_RESUME: begin
        keep   = id_ok;
        cmd.op = ptts_pkg::OP_RESUME;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = accept && keep;

endmodule

@@ sv/ptts_queue.sv @@
// Short command queue between the front end and the task table.
`timescale 1ns / 1ps

module ptts_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ptts_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output ptts_pkg::cmd_t    head,
  output ptts_pkg::q_stat_t q_stat
);

  localparam int QP_W = (ptts_pkg::QUEUE_DEPTH > 1) ? $clog2(ptts_pkg::QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(ptts_pkg::QUEUE_DEPTH + 1);

  ptts_pkg::cmd_t  entries [ptts_pkg::QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr;
  logic [QP_W-1:0] rd_ptr;
  logic [QC_W-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign q_stat.full  = (count == QC_W'(ptts_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QP_W'(ptts_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QP_W'(ptts_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ sv/ptts_back.sv @@
// Back end: task table, command execution and the per-tick walk over all slots.
`timescale 1ns / 1ps

module ptts_back #(
  parameter int NUM_TASKS = ptts_pkg::NUM_TASKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ptts_pkg::q_stat_t           q_stat,
  input  ptts_pkg::cmd_t              head,
  output logic                        pop,
  output logic                        strobe,
  output logic [ptts_pkg::ID_W-1:0]   fired_task,
  output logic                        fired,
  output logic                        last
);

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CD_W  = ptts_pkg::CD_W;
  localparam int WORD_W = 2 * CD_W;

  // task table: state in flops (cleared by reset), reload and countdown in memory
  ptts_pkg::task_st_t  st [NUM_TASKS];
  logic [WORD_W-1:0]   mem [NUM_TASKS];

  ptts_pkg::back_state_t state, state_next;
  logic [IDX_W-1:0]      ptr, ptr_next;
  logic                  pend_v, pend_v_next;
  logic [IDX_W-1:0]      pend_id, pend_id_next;
  logic [ptts_pkg::CNT_W-1:0] n, n_next;

  logic [WORD_W-1:0]     rd_q;
  logic                  proc_v;
  logic                  proc_rdy;
  logic [IDX_W-1:0]      proc_idx;
  logic                  issue;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [WORD_W-1:0]     mem_wdata;
  logic                  st_we;
  logic [IDX_W-1:0]      st_waddr;
  ptts_pkg::task_st_t    st_wdata;

  logic                  emit_v;
  logic [ptts_pkg::ID_W-1:0] emit_id;
  logic                  emit_fired;
  logic                  emit_last;

  logic [IDX_W-1:0]      head_idx;
  logic [CD_W-1:0]       rd_reload;
  logic [CD_W-1:0]       rd_cd;

  assign head_idx  = IDX_W'(head.id);
  assign rd_reload = rd_q[WORD_W-1:CD_W];
  assign rd_cd     = rd_q[CD_W-1:0];

  always_comb begin
    state_next   = state;
    ptr_next     = ptr;
    pend_v_next  = pend_v;
    pend_id_next = pend_id;
    n_next       = n;
    pop          = 1'b0;
    issue        = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = proc_idx;
    mem_wdata    = rd_q;
    st_we        = 1'b0;
    st_waddr     = head_idx;
    st_wdata     = ptts_pkg::ST_NONE;
    emit_v       = 1'b0;
    emit_id      = '0;
    emit_fired   = 1'b0;
    emit_last    = 1'b0;

    case (state)
      ptts_pkg::B_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          case (head.op)
            ptts_pkg::OP_TICK: begin
              state_next  = ptts_pkg::B_WALK;
              ptr_next    = '0;
              pend_v_next = 1'b0;
              n_next      = '0;
            end
            ptts_pkg::OP_CREATE: begin
              st_we     = 1'b1;
              st_wdata  = ptts_pkg::ST_READY;
              mem_we    = 1'b1;
              mem_waddr = head_idx;
              mem_wdata = {head.reload, head.delay};
            end
            // a cleared slot is not updated or fired again before the next create
            ptts_pkg::OP_KILL: begin
              st_we    = 1'b1;
              st_wdata = ptts_pkg::ST_NONE;
            end
            ptts_pkg::OP_SUSPEND: begin
              st_we    = (st[head_idx] != ptts_pkg::ST_NONE);
              st_wdata = ptts_pkg::ST_SUSPENDED;
            end
            ptts_pkg::OP_RESUME: begin
              st_we    = (st[head_idx] != ptts_pkg::ST_NONE);
              st_wdata = ptts_pkg::ST_READY;
            end
            default: begin
              st_we = 1'b0;
            end
          endcase
        end
      end
      ptts_pkg::B_WALK: begin
        issue = 1'b1;
        if (ptr == IDX_W'(NUM_TASKS - 1)) begin
          state_next = ptts_pkg::B_TAIL;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end
      ptts_pkg::B_TAIL: begin
        state_next = ptts_pkg::B_DONE;
      end
      ptts_pkg::B_DONE: begin
        // final transfer of the tick: held firing, or an empty result
        emit_v     = 1'b1;
        emit_id    = pend_v ? ptts_pkg::ID_W'(pend_id) : '0;
        emit_fired = pend_v;
        emit_last  = 1'b1;
        state_next = ptts_pkg::B_IDLE;
      end
      default: begin
        state_next = ptts_pkg::B_IDLE;
      end
    endcase

    // slot update; a firing is held back until the next firing or DONE so that last can be known
    if (proc_v && proc_rdy) begin
      mem_we    = 1'b1;
      mem_waddr = proc_idx;
      if (rd_cd == '0) begin
        mem_wdata = {rd_reload, rd_reload};
        if (n < ptts_pkg::CNT_W'(ptts_pkg::MAX_OUT)) begin
          if (pend_v) begin
            emit_v     = 1'b1;
            emit_id    = ptts_pkg::ID_W'(pend_id);
            emit_fired = 1'b1;
            emit_last  = 1'b0;
          end
          pend_v_next  = 1'b1;
          pend_id_next = proc_idx;
          n_next       = n + 1'b1;
        end
      end else begin
        mem_wdata = {rd_reload, rd_cd - 16'd1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        st[i] <= ptts_pkg::ST_NONE;
      end
    end else if (st_we) begin
      st[st_waddr] <= st_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ptts_pkg::B_IDLE;
      proc_v <= 1'b0;
      pend_v <= 1'b0;
      n      <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      proc_v <= issue;
      pend_v <= pend_v_next;
      n      <= n_next;
      strobe <= emit_v;
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    pend_id    <= pend_id_next;
    proc_idx   <= ptr;
    proc_rdy   <= (st[ptr] == ptts_pkg::ST_READY);
    fired_task <= emit_id;
    fired      <= emit_fired;
    last       <= emit_last;
  end

endmodule

@@ sv/periodic_task_tick_scheduler_unit.sv @@
// Top level of the periodic task tick scheduler.
//
// Command channel: an item (mode, task_id, period, first_delay) is taken at a
// rising edge with start high and busy low. Create, kill, suspend and resume
// change one slot of the task table and give no result; a tick walks every
// slot in order of id. Commands with an unknown mode or a slot beyond the
// table are dropped at the front end.
// Result channel: strobe marks one cycle carrying fired_task, fired and last.
// Each firing on a tick gives one transfer, the final one with last set; a
// tick on which nothing fires gives a single transfer with fired clear.
// Results are not back-pressured: the receiver must take every strobe.
// Timing: a command leaves the queue once the back end is idle; a control
// command writes the table as it leaves. A tick holds the back end while it
// walks the reload/countdown memory one slot per cycle, then passes a tail
// state and a done state; its last result is registered out of the done
// state. The queue holds two commands, so busy rises only when two are
// waiting.
// Reset empties the queue, stops any walk and marks every slot as empty.
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_unit #(
  parameter int NUM_TASKS = ptts_pkg::NUM_TASKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [ptts_pkg::MODE_W-1:0]    mode,
  input  logic [ptts_pkg::ID_W-1:0]      task_id,
  input  logic [ptts_pkg::PER_W-1:0]     period,
  input  logic [ptts_pkg::DELAY_W-1:0]   first_delay,
  output logic                           strobe,
  output logic [ptts_pkg::ID_W-1:0]      fired_task,
  output logic                           fired,
  output logic                           last
);

  ptts_pkg::q_stat_t q_stat;
  ptts_pkg::cmd_t    push_cmd;
  ptts_pkg::cmd_t    head;
  logic              push;
  logic              pop;

  ptts_front #(
    .NUM_TASKS(NUM_TASKS)
  ) u_front (
    .start      (start),
    .mode       (mode),
    .task_id    (task_id),
    .period     (period),
    .first_delay(first_delay),
    .q_stat     (q_stat),
    .busy       (busy),
    .push       (push),
    .cmd        (push_cmd)
  );

  ptts_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .q_stat  (q_stat)
  );

  ptts_back #(
    .NUM_TASKS(NUM_TASKS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .strobe    (strobe),
    .fired_task(fired_task),
    .fired     (fired),
    .last      (last)
  );

endmodule

@@ sv/ptts_checker.sv @@
// Port-level checks for the periodic task tick scheduler, bound to the top level.
`timescale 1ns / 1ps

module ptts_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         busy,
  input logic                         strobe,
  input logic [ptts_pkg::ID_W-1:0]    fired_task,
  input logic                         fired,
  input logic                         last
);

  // an empty tick result is always the only, hence final, transfer
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && !fired) |-> last)
    else $error("empty tick result without last");

  a_empty_id_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && !fired) |-> (fired_task == '0))
    else $error("empty tick result with nonzero task id");

  // an empty result never directly follows an unfinished firing run
  a_no_empty_mid_tick: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> !(strobe && !fired))
    else $error("empty result inside a tick");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!strobe && !busy))
    else $error("activity right after reset");

endmodule

bind periodic_task_tick_scheduler_unit ptts_checker u_ptts_checker (
  .clk       (clk),
  .rst       (rst),
  .busy      (busy),
  .strobe    (strobe),
  .fired_task(fired_task),
  .fired     (fired),
  .last      (last)
);
